// ===== rtl/core/fpa_pkg.sv =====
// Shared operation codes and types for the fixed-point ALU.
package fpa_pkg;

  typedef enum logic [3:0] {
    FN_ADD = 4'd0, FN_SUB = 4'd1, FN_MUL = 4'd2, FN_DIV = 4'd3,
    FN_GT = 4'd4, FN_LT = 4'd5, FN_GE = 4'd6, FN_LE = 4'd7,
    FN_EQ = 4'd8, FN_NE = 4'd9, FN_MAX = 4'd10, FN_MIN = 4'd11,
    FN_INC = 4'd12, FN_DEC = 4'd13, FN_FROM_INT = 4'd14, FN_TO_INT = 4'd15
  } func_t;

  localparam int FUNC_WIDTH = 4;

endpackage

// ===== rtl/core/fpa_if.sv =====
// Valid/ready channel carrying one ALU request or result.
interface fpa_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic [fpa_pkg::FUNC_WIDTH-1:0] func;
  logic signed [VALUE_WIDTH-1:0]  operand_a;
  logic signed [VALUE_WIDTH-1:0]  operand_b;
  logic signed [VALUE_WIDTH-1:0]  value_out;
  logic                           compare_true;
  logic                           divide_by_zero;

  modport source (output valid, func, operand_a, operand_b, value_out, compare_true,
                  divide_by_zero, input ready);
  modport sink (input valid, func, operand_a, operand_b, value_out, compare_true,
                divide_by_zero, output ready);
endinterface

// ===== rtl/core/fixed_point_alu_core.sv =====
// Top level of the signed fixed-point ALU pipeline.
//
// Usage: requests enter on req (func, operand_a, operand_b) and results leave
// on rsp (value_out, compare_true, divide_by_zero) through valid/ready
// channels; an item moves at an edge with valid and ready both high.
// Throughput: one request per cycle while the output is not stalled. A result
// becomes valid after the request passes through the pipe, whose depth the
// divider's stage count plus one output register sets, with the multiplier and
// simple operations delayed to match.
// Results come out in request order, one per request.
// Reset: rst clears every valid bit; data registers are left as they are.
// Stall: when the receiver drops ready with a result waiting, the whole pipe
// holds; req.ready is high whenever the output stage is empty or being taken,
// so bubbles inside the pipe are not squeezed out while stalled.
// Add, subtract, compares, min/max, inc/dec and conversions are computed at
// entry and delayed; multiply and divide use their own pipelined units.
module fixed_point_alu_core #(
  parameter int FRAC_BITS   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  fpa_if.sink   req,
  fpa_if.source rsp
);
  localparam int W   = VALUE_WIDTH;
  localparam int DS  = 6;
  localparam int LAT = DS + 1;

  logic en;
  logic [LAT-1:0] vld;
  logic [W-1:0] mul_p, div_q;

  // Advance whenever the last stage is empty or taken
  assign en        = !vld[LAT-1] || rsp.ready;
  assign req.ready = en;

  fpa_mul #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .en(en), .a(req.operand_a), .b(req.operand_b), .p(mul_p));
  fpa_div #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS), .STAGES(DS)) u_div (
    .clk(clk), .en(en), .a(req.operand_a), .b(req.operand_b), .q(div_q));

  // Simple operations at entry
  logic signed [W-1:0] a, b, v0;
  logic lt_ab, lt_ba, c0, dz0;
  fpa_pkg::func_t fn;
  always_comb begin
    a = req.operand_a;
    b = req.operand_b;
    fn = fpa_pkg::func_t'(req.func);
    lt_ab = a < b;
    lt_ba = b < a;
    v0 = '0;
    c0 = 1'b0;
    dz0 = 1'b0;
    case (fn)
      fpa_pkg::FN_ADD:      v0 = a + b;
      fpa_pkg::FN_SUB:      v0 = a - b;
      fpa_pkg::FN_DIV:      dz0 = (b == '0);
      fpa_pkg::FN_GT:       c0 = lt_ba;
      fpa_pkg::FN_LT:       c0 = lt_ab;
      fpa_pkg::FN_GE:       c0 = !lt_ab;
      fpa_pkg::FN_LE:       c0 = !lt_ba;
      fpa_pkg::FN_EQ:       c0 = (a == b);
      fpa_pkg::FN_NE:       c0 = (a != b);
      fpa_pkg::FN_MAX:      v0 = lt_ba ? a : b;
      fpa_pkg::FN_MIN:      v0 = lt_ab ? a : b;
      fpa_pkg::FN_INC:      v0 = a + W'(1);
      fpa_pkg::FN_DEC:      v0 = a - W'(1);
      fpa_pkg::FN_FROM_INT: v0 = a <<< FRAC_BITS;
      fpa_pkg::FN_TO_INT:   v0 = a >>> FRAC_BITS;
      default:              v0 = '0;
    endcase
  end

  // Delay line for side results and selection codes
  logic [W-1:0] v_d  [LAT];
  logic [1:0]   sel_d[LAT];
  logic         c_d  [LAT];
  logic         dz_d [LAT];
  logic [1:0]   sel0;
  assign sel0 = (fn == fpa_pkg::FN_MUL) ? 2'd1 :
                ((fn == fpa_pkg::FN_DIV) && !dz0) ? 2'd2 : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_d[0] <= v0; sel_d[0] <= sel0; c_d[0] <= c0; dz_d[0] <= dz0;
      for (int i = 1; i < LAT; i++) begin
        v_d[i] <= v_d[i-1]; sel_d[i] <= sel_d[i-1];
        c_d[i] <= c_d[i-1]; dz_d[i] <= dz_d[i-1];
      end
    end
  end

  // Hold the divider output one more stage so it lines up with the last valid bit
  logic [W-1:0] div_hold;
  always_ff @(posedge clk) begin
    if (en) begin
      div_hold <= div_q;
    end
  end

  // Pick the multiplier output when it is due, tap the delay line accordingly
  logic [W-1:0] mul_hold;
  always_ff @(posedge clk) begin
    if (en) begin
      mul_hold <= mul_p;
    end
  end
  logic [W-1:0] mul_late [LAT-4];
  always_ff @(posedge clk) begin
    if (en) begin
      mul_late[0] <= mul_hold;
      for (int i = 1; i < LAT - 4; i++) mul_late[i] <= mul_late[i-1];
    end
  end

  assign rsp.valid          = vld[LAT-1];
  assign rsp.value_out      = (sel_d[LAT-1] == 2'd1) ? mul_late[LAT-5] :
                              (sel_d[LAT-1] == 2'd2) ? div_hold : v_d[LAT-1];
  assign rsp.compare_true   = c_d[LAT-1];
  assign rsp.divide_by_zero = dz_d[LAT-1];
  assign rsp.func           = '0;
  assign rsp.operand_a      = '0;
  assign rsp.operand_b      = '0;
endmodule

// ===== rtl/core/fpa_mul.sv =====
// Pipelined multiplier: magnitude product from 16-bit operand halves, then scale.
module fpa_mul #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 8
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output logic [VALUE_WIDTH-1:0] p
);
  localparam int W  = VALUE_WIDTH;
  localparam int HW = (W + 1) / 2;
  localparam int PW = 2 * W;

  logic [W-1:0]    mag_a, mag_b;
  logic [2*HW-1:0] ll, lh, hl, hh;
  logic            neg_1;
  logic [PW-1:0]   prod;
  logic            neg_2;
  logic [PW-1:0]   sum;
  logic [PW-1:0]   scaled;

  // Take operand magnitudes
  assign mag_a = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b = b[W-1] ? (~b + 1'b1) : b;

  // Stage 0: form four partial products of the half-width operand pieces
  always_ff @(posedge clk) begin
    if (en) begin
      neg_1 <= a[W-1] ^ b[W-1];
      ll <= HW'(mag_a) * HW'(mag_b);
      lh <= HW'(mag_a) * HW'(mag_b >> HW);
      hl <= HW'(mag_a >> HW) * HW'(mag_b);
      hh <= HW'(mag_a >> HW) * HW'(mag_b >> HW);
    end
  end

  // Stage 1: sum partial products
  assign sum = PW'(ll) + (PW'(lh) << HW) + (PW'(hl) << HW) + (PW'(hh) << (2 * HW));
  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= sum;
      neg_2 <= neg_1;
    end
  end

  // Stage 2: scale, restore sign, wrap
  assign scaled = prod >> FRAC_BITS;
  always_ff @(posedge clk) begin
    if (en) begin
      p <= neg_2 ? W'(~scaled + 1'b1) : W'(scaled);
    end
  end
endmodule

// ===== rtl/core/fpa_div.sv =====
// Pipelined restoring divider: a group of quotient bits per stage.
module fpa_div #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 8,
  parameter int STAGES      = 6
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [VALUE_WIDTH-1:0] a,
  input  logic [VALUE_WIDTH-1:0] b,
  output logic [VALUE_WIDTH-1:0] q
);
  localparam int W   = VALUE_WIDTH;
  localparam int NW  = W + FRAC_BITS;
  localparam int BPS = (NW + STAGES - 1) / STAGES;
  localparam int TOT = BPS * STAGES;
  localparam int RW  = W + 1;

  // Per stage registered state: remaining dividend bits, remainder, quotient
  logic [TOT-1:0] num_s [STAGES+1];
  logic [RW-1:0]  rem_s [STAGES+1];
  logic [TOT-1:0] quo_s [STAGES+1];
  logic [W-1:0]   den_s [STAGES+1];
  logic           neg_s [STAGES+1];

  logic [W-1:0] mag_a, mag_b;
  assign mag_a = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b = b[W-1] ? (~b + 1'b1) : b;

  // Stage entry values
  always_comb begin
    num_s[0] = TOT'({mag_a, {FRAC_BITS{1'b0}}});
    rem_s[0] = '0;
    quo_s[0] = '0;
    den_s[0] = mag_b;
    neg_s[0] = a[W-1] ^ b[W-1];
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [TOT-1:0] num_c, quo_c;
    logic [RW-1:0]  rem_c;
    logic [RW:0]    trial;
    always_comb begin
      num_c = num_s[s];
      rem_c = rem_s[s];
      quo_c = quo_s[s];
      for (int i = 0; i < BPS; i++) begin
        trial = {rem_c, num_c[TOT-1]} - {2'b00, den_s[s]};
        num_c = num_c << 1;
        if (!trial[RW]) begin
          rem_c = trial[RW-1:0];
          quo_c = {quo_c[TOT-2:0], 1'b1};
        end else begin
          rem_c = {rem_c[RW-2:0], num_s[s][TOT-1-i]};
          quo_c = {quo_c[TOT-2:0], 1'b0};
        end
      end
    end
    // Advance one stage
    always_ff @(posedge clk) begin
      if (en) begin
        num_s[s+1] <= num_c;
        rem_s[s+1] <= rem_c;
        quo_s[s+1] <= quo_c;
        den_s[s+1] <= den_s[s];
        neg_s[s+1] <= neg_s[s];
      end
    end
  end

  assign q = neg_s[STAGES] ? W'(~quo_s[STAGES] + 1'b1) : W'(quo_s[STAGES]);
endmodule

// ===== test/fixed_point_alu_checker.sv =====
// Checker for the fixed-point ALU: predicts each result and compares it.
`timescale 1ns / 1ps
module fixed_point_alu_checker #(
  parameter int FRAC_BITS   = 8,
  parameter int VALUE_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  fpa_if.sink req,
  fpa_if.sink rsp,
  output int  fail_count,
  output int  pending_count,
  output int  result_count
);

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   cmp;
    logic                   dz;
  } alu_result_t;

  alu_result_t expected_results[$];

  // Compute the result of one request at full precision.
  function automatic alu_result_t alu_predict(logic [3:0] fn,
                                              logic signed [VALUE_WIDTH-1:0] a,
                                              logic signed [VALUE_WIDTH-1:0] b);
    alu_result_t r;
    logic signed [2*VALUE_WIDTH+FRAC_BITS:0] wide;
    logic signed [2*VALUE_WIDTH+FRAC_BITS:0] num;
    logic signed [2*VALUE_WIDTH+FRAC_BITS:0] den;
    r = '0;
    case (fpa_pkg::func_t'(fn))
      fpa_pkg::FN_ADD: r.value = a + b;
      fpa_pkg::FN_SUB: r.value = a - b;
      fpa_pkg::FN_MUL: begin
        // truncate toward zero: divide rather than shift
        wide = a;
        wide = wide * b;
        wide = wide / (1 <<< FRAC_BITS);
        r.value = wide[VALUE_WIDTH-1:0];
      end
      fpa_pkg::FN_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = a;
          num = num <<< FRAC_BITS;
          den = b;
          wide = num / den;
          r.value = wide[VALUE_WIDTH-1:0];
        end
      end
      fpa_pkg::FN_GT: r.cmp = a > b;
      fpa_pkg::FN_LT: r.cmp = a < b;
      fpa_pkg::FN_GE: r.cmp = a >= b;
      fpa_pkg::FN_LE: r.cmp = a <= b;
      fpa_pkg::FN_EQ: r.cmp = a == b;
      fpa_pkg::FN_NE: r.cmp = a != b;
      fpa_pkg::FN_MAX: r.value = (a > b) ? a : b;
      fpa_pkg::FN_MIN: r.value = (a < b) ? a : b;
      fpa_pkg::FN_INC: r.value = a + 1;
      fpa_pkg::FN_DEC: r.value = a - 1;
      fpa_pkg::FN_FROM_INT: r.value = a <<< FRAC_BITS;
      default: r.value = a >>> FRAC_BITS;
    endcase
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // Queue a prediction per accepted request; compare each accepted result.
  always @(posedge clk) begin
    alu_result_t exp_r;
    if (rst) begin
      fail_count   <= 0;
      result_count <= 0;
    end else begin
      if (req.valid && req.ready)
        expected_results.push_back(alu_predict(req.func, req.operand_a, req.operand_b));
      if (rsp.valid && rsp.ready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value=%h", $time, rsp.value_out);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.value !== rsp.value_out || exp_r.cmp !== rsp.compare_true ||
              exp_r.dz !== rsp.divide_by_zero) begin
            $display("%0t: mismatch expected value=%h cmp=%b dz=%b actual value=%h cmp=%b dz=%b",
                     $time, exp_r.value, exp_r.cmp, exp_r.dz,
                     rsp.value_out, rsp.compare_true, rsp.divide_by_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/fixed_point_alu_core_test.sv =====
// Top of the fixed-point ALU testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module fixed_point_alu_core_test;

  localparam int NUM_RANDOM  = 1100;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending_count, result_count;
  int   idle_cycles = 0;
  int   sent = 0;
  bit   timed_out = 1'b0;
  bit   calm_phase = 1'b0;
  bit   hold_off = 1'b0;

  fpa_if #(.VALUE_WIDTH(32)) req ();
  fpa_if #(.VALUE_WIDTH(32)) rsp ();

  fixed_point_alu_core dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  fixed_point_alu_checker chk (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  always #5 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.func = '0;
    req.operand_a = '0;
    req.operand_b = '0;
    rsp.ready = 1'b0;
  end

  // Pick an operand: extremes, small values or full random.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 4) - 2;
      3: return 32'($signed($urandom_range(0, 4096)) - 2048);
      4: return (32'($urandom_range(0, 7)) << 8) - 32'h400;
      default: return $urandom();
    endcase
  endfunction

  // Offer one request and hold it until accepted.
  task automatic send_request(input logic [3:0] fn, input logic [31:0] a,
                              input logic [31:0] b);
    while (!calm_phase && $urandom_range(0, 99) < 34) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.func      <= fn;
    req.operand_a <= a;
    req.operand_b <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off.
  always @(posedge clk) begin
    if (rst || hold_off) begin
      rsp.ready <= 1'b0;
    end else if (calm_phase) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= 34);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_off) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        timed_out = 1'b1;
        $display("fixed_point_alu_core_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] fn;
    int         drain;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every operation on the extremes, divide by zero, rounding.
    for (int f = 0; f < 16; f++)
      send_request(f[3:0], 32'h8000_0000, 32'h7fff_ffff);
    send_request(fpa_pkg::FN_DIV, 32'h0000_0300, 32'h0000_0000);
    send_request(fpa_pkg::FN_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_request(fpa_pkg::FN_DIV, 32'hffff_fd00, 32'h0000_0200);
    send_request(fpa_pkg::FN_MUL, 32'hffff_ffff, 32'h0000_0001);
    send_request(fpa_pkg::FN_MUL, 32'h8000_0000, 32'h8000_0000);
    send_request(fpa_pkg::FN_TO_INT, 32'hffff_ff01, 32'h0);
    send_request(fpa_pkg::FN_EQ, 32'h1234_5678, 32'h1234_5678);
    send_request(fpa_pkg::FN_INC, 32'h7fff_ffff, 32'h0);
    send_request(fpa_pkg::FN_DEC, 32'h8000_0000, 32'hffff_ffff);

    // Random requests; a calm stretch and a long receiver hold-off midway.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) calm_phase = 1'b1;
      if (i == 450) calm_phase = 1'b0;
      if (i == 600) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (60) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      fn = 4'($urandom_range(0, 15));
      send_request(fn, pick_operand(), pick_operand());
    end
    req.valid <= 1'b0;

    // Drain outstanding results, then allow pipeline latency.
    drain = 0;
    while (pending_count != 0 && drain < STALL_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    $display("Sent %0d requests covering all 16 operations, extremes and divide by zero;",
             sent);
    $display("received %0d results, with random stalls on both sides.", result_count);
    if (fail_count == 0 && pending_count == 0 && !timed_out) begin
      $display("fixed_point_alu_core_test OK");
    end else begin
      $display("fixed_point_alu_core_test NOT OK");
    end
    $finish;
  end
endmodule
